/* rtl/snooping_bus_main_memory_core_assert.svh */
// assertion macros for the checker file
`ifndef SNOOPING_BUS_MAIN_MEMORY_CORE_ASSERT_SVH
`define SNOOPING_BUS_MAIN_MEMORY_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define SBMM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbmm assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define SBMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbmm assertion failed");

`endif

/* rtl/sbmm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_pkg
// Types and constants of the snooping bus main memory responder.
// ----------------------------------------------------------------------------
package sbmm_pkg;

  localparam int AddrBits   = 20;
  localparam int StoreDepth = 1 << AddrBits;

  localparam logic [2:0] MemOriginId = 3'd4;

  // configuration register map
  localparam int          PAddrW          = 3;
  localparam logic        RegIdxWaitCycles = 1'b0;
  localparam logic [7:0]  WaitCyclesReset  = 8'd16;

  typedef enum logic [1:0] {
    FUNC_NONE   = 2'd0,
    FUNC_BUSRD  = 2'd1,
    FUNC_BUSRDX = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  origin_id;
    logic [19:0] word_addr;
    logic [31:0] word_data;
    logic [2:0]  caller_id;
    logic        bus_already_driven;
  } req_t;

  typedef struct packed {
    logic        flush_valid;
    logic [19:0] flush_address;
    logic [31:0] flush_data;
    logic        read_pending;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_valid;
  } status_t;

endpackage

/* rtl/sbmm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_req_if / sbmm_rsp_if
// Valid/ready channels for bus snapshots and responder results.
// ----------------------------------------------------------------------------
interface sbmm_req_if import sbmm_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

interface sbmm_rsp_if import sbmm_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

/* rtl/snooping_bus_main_memory_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snooping_bus_main_memory_core
// Main memory responder on a snooping MESI bus.
// ----------------------------------------------------------------------------
// After reset the word store is swept to zero, one word per cycle, over all
// 2^20 = 1,048,576 words; no bus transaction is accepted during the sweep,
// while wait_cycles writes are taken at any time. Afterwards each bus
// snapshot is handled in the accept cycle, in which the countdown and the
// pending request update and the store is read at the pending address, then
// in ST_RESP, which loads the registered store data into the output register
// once it is free or being emptied. One result comes out per snapshot; the
// output register lets the next snapshot be accepted while a result waits.
// wait_cycles sits at byte address 0 of the APB port (reset 16).
module snooping_bus_main_memory_core
  import sbmm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  sbmm_req_if.sink           req_i,
  sbmm_rsp_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PAddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] wait_cycles_q;
  logic       reg_sel;
  cmd_t       cmd;
  status_t    status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PAddrW-1] == RegIdxWaitCycles);
  assign prdata  = reg_sel ? 32'(wait_cycles_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_cycles_q <= WaitCyclesReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      wait_cycles_q <= pwdata[7:0];
    end
  end

  sbmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sbmm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_i         (req_i.payload),
    .wait_cycles_i (wait_cycles_q),
    .rsp_ready_i   (rsp_o.ready),
    .status_o      (status),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_o         (rsp_o.payload)
  );

endmodule

/* rtl/sbmm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_ctrl
// Sequencer: store clearing sweep, transaction accept, result hand-off.
// ----------------------------------------------------------------------------
module sbmm_ctrl
  import sbmm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  logic    rsp_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
        if (req_valid_i) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        // output register is free or being emptied this cycle
        if (!status_i.out_valid || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/sbmm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_datapath
// Word store, read countdown, pending request and result register.
// ----------------------------------------------------------------------------
module sbmm_datapath
  import sbmm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  req_t       req_i,
  input  logic [7:0] wait_cycles_i,
  input  logic       rsp_ready_i,
  output status_t    status_o,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o
);

  logic [31:0]         mem_q [StoreDepth];
  logic [31:0]         mem_rdata_q;
  logic [AddrBits-1:0] clr_cnt_q;

  logic [7:0]          cnt_q, cnt_d;
  logic [AddrBits-1:0] pend_addr_q, pend_addr_d;
  logic [2:0]          pend_req_q, pend_req_d;

  logic                reply_q, reply_d;
  logic                busy_q;
  logic                out_valid_q;
  rsp_t                out_q;

  logic                is_flush, is_read, is_tick;
  logic [AddrBits-1:0] req_idx;
  logic                mem_we;
  logic [AddrBits-1:0] mem_waddr;
  logic [31:0]         mem_wdata;

  assign req_idx  = AddrBits'(req_i.word_addr);
  assign is_flush = (req_i.func == FUNC_FLUSH) && (req_i.origin_id != MemOriginId);
  assign is_read  = (req_i.func == FUNC_BUSRD) || (req_i.func == FUNC_BUSRDX);
  assign is_tick  = (req_i.func == FUNC_NONE) && (cnt_q != 8'd0)
                    && (req_i.caller_id == pend_req_q);

  always_comb begin
    cnt_d       = cnt_q;
    pend_addr_d = pend_addr_q;
    pend_req_d  = pend_req_q;
    reply_d     = 1'b0;
    priority if (is_flush) begin
      cnt_d = 8'd0;
    end else if (is_read) begin
      cnt_d       = wait_cycles_i;
      pend_addr_d = req_idx;
      pend_req_d  = req_i.origin_id;
    end else if (is_tick) begin
      cnt_d   = cnt_q - 8'd1;
      // last tick answers unless the next bus cycle is taken
      reply_d = (cnt_q == 8'd1) && !req_i.bus_already_driven;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_idx;
    mem_wdata = req_i.word_data;
    if (cmd_i.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (cmd_i.accept && is_flush) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.accept) begin
      mem_rdata_q <= mem_q[pend_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
      pend_addr_q <= '0;
      pend_req_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        cnt_q       <= cnt_d;
        pend_addr_q <= pend_addr_d;
        pend_req_q  <= pend_req_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      reply_q <= reply_d;
      busy_q  <= (cnt_d != 8'd0);
    end
    if (cmd_i.load_out) begin
      out_q.flush_valid   <= reply_q;
      out_q.flush_address <= reply_q ? 20'(pend_addr_q) : 20'd0;
      out_q.flush_data    <= reply_q ? mem_rdata_q : 32'd0;
      out_q.read_pending  <= busy_q;
    end
  end

  assign status_o.clr_last  = &clr_cnt_q;
  assign status_o.out_valid = out_valid_q;
  assign rsp_valid_o        = out_valid_q;
  assign rsp_o              = out_q;

endmodule

/* rtl/sbmm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_checker
// Port-level checks of the main memory responder, bound to the top level.
// ----------------------------------------------------------------------------
`include "snooping_bus_main_memory_core_assert.svh"

module sbmm_checker
  import sbmm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_payload_i
);

  logic req_xfer;
  logic rsp_stall;
  logic rsp_flush;

  assign req_xfer  = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign rsp_flush = rsp_valid_i && rsp_payload_i.flush_valid;

  // a result waiting on the sink stays offered
  `SBMM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i)
  // one snapshot in flight: no accept right after an accept
  `SBMM_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_xfer, !req_ready_i)
  // a reply ends the countdown
  `SBMM_ASSERT_SAME(a_reply_ends_read, clk_i, rst_ni, rsp_flush, !rsp_payload_i.read_pending)
  // no reply means zero address and data
  `SBMM_ASSERT_SAME(a_quiet_payload, clk_i, rst_ni,
    rsp_valid_i && !rsp_payload_i.flush_valid,
    rsp_payload_i.flush_address == 20'd0 && rsp_payload_i.flush_data == 32'd0)

endmodule

bind snooping_bus_main_memory_core sbmm_checker u_sbmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the main memory responder of the snooping bus. Bus snapshots are
// streamed in over the request channel, an in-bench model of the store and
// the read countdown works out the reply of each one, and every reply
// transaction is compared field by field. Several wait_cycles settings are
// written over the APB port between phases, with nothing outstanding, zero and 255 among them.
// ----------------------------------------------------------------------------
module testbench;
  import sbmm_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PAddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sbmm_req_if req_if ();
  sbmm_rsp_if rsp_if ();

  snooping_bus_main_memory_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  req_t bus_snapshots[$];
  rsp_t expected_replies[$];
  int   mismatches;

  // memory image and read tracking as the block should hold them
  logic [31:0] mem_image[logic [19:0]];
  logic [7:0]  model_count;
  logic [19:0] model_addr;
  logic [2:0]  model_requester;
  logic [7:0]  model_wait;

  logic [19:0] addr_pool[8];

  int send_gap;
  int send_calm;
  int recv_gap;
  int recv_calm;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(100_000_000);
    $display("FAIL snooping_bus_main_memory_core");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic req_t bus_item(input func_e f, input logic [2:0] origin,
                                    input logic [19:0] addr, input logic [31:0] data,
                                    input logic [2:0] caller, input logic driven);
    req_t it;
    it.func = f;
    it.origin_id = origin;
    it.word_addr = addr;
    it.word_data = data;
    it.caller_id = caller;
    it.bus_already_driven = driven;
    return it;
  endfunction

  function automatic logic [19:0] pick_address();
    if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, 7)];
    return 20'($urandom);
  endfunction

  function automatic void predict_memory_reply(input req_t it);
    rsp_t r;
    func_e f;
    f = func_e'(it.func);
    r = '0;
    if (f == FUNC_FLUSH && it.origin_id != MemOriginId) begin
      model_count = '0;
      mem_image[it.word_addr] = it.word_data;
    end else if (f == FUNC_BUSRD || f == FUNC_BUSRDX) begin
      model_count = model_wait;
      model_addr = it.word_addr;
      model_requester = it.origin_id;
    end else if (f == FUNC_NONE && model_count != 0 && it.caller_id == model_requester) begin
      model_count = model_count - 8'd1;
      // reply is lost when the next bus cycle is already claimed
      if (model_count == 0 && !it.bus_already_driven) begin
        r.flush_valid = 1'b1;
        r.flush_address = model_addr;
        r.flush_data = mem_image.exists(model_addr) ? mem_image[model_addr] : 32'd0;
      end
    end
    r.read_pending = (model_count != 0);
    expected_replies.push_back(r);
  endfunction

  function automatic void check_reply(input rsp_t got);
    rsp_t want;
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected reply: valid=%0d addr=%05h data=%08h pending=%0d",
                 got.flush_valid, got.flush_address, got.flush_data, got.read_pending);
      return;
    end
    want = expected_replies.pop_front();
    if (got.flush_valid !== want.flush_valid || got.flush_address !== want.flush_address ||
        got.flush_data !== want.flush_data || got.read_pending !== want.read_pending) begin
      mismatches++;
      if (mismatches <= 10)
        $display("reply mismatch: exp valid=%0d addr=%05h data=%08h pending=%0d, %s",
                 want.flush_valid, want.flush_address, want.flush_data, want.read_pending,
                 $sformatf("got valid=%0d addr=%05h data=%08h pending=%0d",
                           got.flush_valid, got.flush_address, got.flush_data,
                           got.read_pending));
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_if.ready)) begin
      if (send_gap > 0) begin
        req_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (bus_snapshots.size() != 0) begin
        req_if.payload <= bus_snapshots.pop_front();
        req_if.valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
        end else begin
          send_gap <= gap_len();
          if ($urandom_range(0, 99) < 3) send_calm <= $urandom_range(30, 100);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // reply side back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        rsp_if.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm <= recv_calm - 1;
        end else begin
          recv_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
          if ($urandom_range(0, 99) < 2) recv_calm <= $urandom_range(30, 100);
        end
      end
    end
  end

  // monitor: predict on each accepted snapshot, check each reply transaction
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) predict_memory_reply(req_if.payload);
    if (rst_ni && rsp_if.valid && rsp_if.ready) check_reply(rsp_if.payload);
  end

  task automatic write_wait_cycles(input logic [7:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PAddrW'(4 * int'(RegIdxWaitCycles));
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_wait = value;
  endtask

  task automatic wait_for_quiet();
    do @(negedge clk_i);
    while (bus_snapshots.size() != 0 || req_if.valid || expected_replies.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic queue_random_phase(input int n);
    int made;
    int r;
    int plan;
    logic [2:0] who;
    logic [2:0] origin;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // read followed by the idle slots that walk its countdown down
        who = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
        bus_snapshots.push_back(bus_item($urandom_range(0, 1) ? FUNC_BUSRD : FUNC_BUSRDX, who,
                                         pick_address(), $urandom, 3'($urandom),
                                         1'($urandom)));
        made++;
        plan = ($urandom_range(0, 6) == 0) ? $urandom_range(0, int'(model_wait))
                                           : int'(model_wait) + $urandom_range(0, 2);
        for (int k = 0; k < plan; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            bus_snapshots.push_back(bus_item(FUNC_NONE, 3'($urandom), 20'($urandom), $urandom,
                                             who + 3'($urandom_range(1, 7)), 1'($urandom)));
            made++;
          end
          bus_snapshots.push_back(bus_item(FUNC_NONE, 3'($urandom), 20'($urandom), $urandom,
                                           who, $urandom_range(0, 9) == 0));
          made++;
        end
      end else if (r < 82) begin
        origin = 3'($urandom);
        if (origin == MemOriginId) origin = 3'($urandom_range(0, 3));
        bus_snapshots.push_back(bus_item(FUNC_FLUSH, origin, pick_address(), $urandom,
                                         3'($urandom), 1'($urandom)));
        made++;
      end else if (r < 87) begin
        bus_snapshots.push_back(bus_item(FUNC_FLUSH, MemOriginId, pick_address(), $urandom,
                                         3'($urandom), 1'($urandom)));
        made++;
      end else begin
        bus_snapshots.push_back(bus_item(func_e'($urandom_range(0, 3)), 3'($urandom),
                                         20'($urandom), $urandom, 3'($urandom),
                                         1'($urandom)));
        made++;
      end
    end
  endtask

  initial begin
    mismatches = 0;
    model_count = '0;
    model_addr = '0;
    model_requester = '0;
    model_wait = WaitCyclesReset;
    send_gap = 0;
    send_calm = 0;
    recv_gap = 0;
    recv_calm = 0;
    addr_pool[0] = 20'h00000;
    addr_pool[1] = 20'hFFFFF;
    for (int i = 2; i < 8; i++) addr_pool[i] = 20'($urandom);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero wait: a read never answers
    write_wait_cycles(8'd0);
    bus_snapshots.push_back(bus_item(FUNC_BUSRD, 3'd0, 20'h00000, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd0, 1'b1));
    wait_for_quiet();

    write_wait_cycles(8'd2);
    // cache outside the id range writes, memory's own flush is ignored
    bus_snapshots.push_back(bus_item(FUNC_FLUSH, 3'd7, 20'hFFFFF, 32'hFFFFFFFF, 3'd7, 1'b1));
    bus_snapshots.push_back(bus_item(FUNC_FLUSH, MemOriginId, 20'hFFFFF, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_FLUSH, 3'd0, 20'h00000, 32'h5A5A5A5A, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_BUSRDX, 3'd7, 20'hFFFFF, 32'd0, 3'd0, 1'b0));
    // other caller holds the countdown
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd7, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd7, 1'b0));
    // idle with nothing pending
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd7, 1'b0));
    // lost reply on a claimed bus cycle
    bus_snapshots.push_back(bus_item(FUNC_BUSRD, 3'd1, 20'h00005, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd1, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd1, 1'b1));
    // a new read replaces the pending one
    bus_snapshots.push_back(bus_item(FUNC_BUSRD, 3'd2, 20'h00000, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_BUSRDX, 3'd3, 20'hFFFFF, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd2, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd3, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd3, 1'b0));
    // flush cancels a pending read
    bus_snapshots.push_back(bus_item(FUNC_BUSRD, 3'd0, 20'h00000, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_FLUSH, 3'd6, 20'h00000, 32'h12345678, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_BUSRD, MemOriginId, 20'h00000, 32'd0, 3'd0, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, MemOriginId, 1'b0));
    bus_snapshots.push_back(bus_item(FUNC_NONE, 3'd0, 20'h00000, 32'd0, MemOriginId, 1'b0));
    wait_for_quiet();

    write_wait_cycles(8'd1);
    queue_random_phase(300);
    wait_for_quiet();

    write_wait_cycles(8'd255);
    queue_random_phase(280);
    wait_for_quiet();

    write_wait_cycles(8'($urandom_range(2, 12)));
    queue_random_phase(420);
    wait_for_quiet();

    write_wait_cycles(8'd0);
    queue_random_phase(100);
    wait_for_quiet();

    write_wait_cycles(8'($urandom_range(1, 30)));
    queue_random_phase(300);
    wait_for_quiet();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS snooping_bus_main_memory_core");
    end else begin
      $display("FAIL snooping_bus_main_memory_core");
    end
    $finish;
  end

endmodule
